/* design/dewu_pkg.sv */
`default_nettype none

package dewu_pkg;

    localparam int LIST_DEPTH_DEF = 48;
    localparam int TRIG_DEPTH_DEF = 16;

    localparam int WORD_W   = 32;
    localparam int LEN_W    = 13;
    localparam int CHAN_W   = 4;
    localparam int VALUE_W  = 30;
    localparam int SLOT_W   = 6;
    localparam int BROKEN_W = 16;

    // readout word type codes
    localparam logic [3:0] TYPE_HIT    = 4'b0001;
    localparam logic [3:0] TYPE_EXT_TS = 4'b0010;
    localparam logic [1:0] MARK_EVT_TS = 2'b11;

    // channel map of the hit lists
    localparam logic [5:0] TDIFF_BASE = 6'd16;
    localparam logic [5:0] TRIG_BASE  = 6'd32;
    localparam logic [5:0] TRIG_END   = 6'd34;
    localparam logic [5:0] SHORT_BASE = 6'd48;

    localparam logic [BROKEN_W-1:0] BROKEN_MAX = '1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_MODHDR,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_LONG,
        CLS_SHORT,
        CLS_TDIFF,
        CLS_TRIG,
        CLS_EXT_TS,
        CLS_EVT_TS,
        CLS_BROKEN
    } class_t;

    typedef struct packed {
        logic                decode;
        logic                broken;
        logic                done;
        logic [BROKEN_W-1:0] broken_total;
    } frame_t;

    typedef struct packed {
        class_t             word_class;
        logic [CHAN_W-1:0]  hit_channel;
        logic [VALUE_W-1:0] word_value;
        logic [SLOT_W-1:0]  list_slot;
    } decode_t;

endpackage

`default_nettype wire

/* design/dewu_framer.sv */
`default_nettype none

module dewu_framer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              advance,
    input  wire logic [dewu_pkg::LEN_W-1:0]        word_len,
    output dewu_pkg::frame_t                       frame
);

    dewu_pkg::phase_t                  phase_reg, phase_next;
    logic [dewu_pkg::LEN_W-1:0]        words_left_reg, words_left_next;
    logic [dewu_pkg::LEN_W-1:0]        words_dec;
    logic [dewu_pkg::BROKEN_W-1:0]     broken_reg, broken_next;

    assign words_dec = (words_left_reg != '0) ? words_left_reg - 1'b1 : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= dewu_pkg::PH_HEADER;
            words_left_reg <= '0;
            broken_reg     <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            broken_reg     <= broken_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        words_left_next = words_left_reg;
        broken_next     = broken_reg;
        frame.decode    = 1'b0;
        frame.broken    = 1'b0;
        frame.done      = 1'b0;
        case (phase_reg)
            dewu_pkg::PH_HEADER: begin
                if (word_len > dewu_pkg::LEN_W'(1)) begin
                    words_left_next = word_len - 1'b1;
                    phase_next      = dewu_pkg::PH_MODHDR;
                end else if (word_len == dewu_pkg::LEN_W'(1)) begin
                    words_left_next = '0;
                    phase_next      = dewu_pkg::PH_SKIP;
                end else begin
                    // empty block, header closes it
                    words_left_next = '0;
                    frame.done      = 1'b1;
                end
            end
            dewu_pkg::PH_MODHDR: begin
                phase_next = (words_left_reg != '0) ? dewu_pkg::PH_DATA
                                                    : dewu_pkg::PH_HEADER;
            end
            dewu_pkg::PH_DATA: begin
                frame.decode    = 1'b1;
                words_left_next = words_dec;
                if (words_dec == '0) begin
                    phase_next = dewu_pkg::PH_HEADER;
                    frame.done = 1'b1;
                end
            end
            dewu_pkg::PH_SKIP: begin
                frame.broken = 1'b1;
                frame.done   = 1'b1;
                phase_next   = dewu_pkg::PH_HEADER;
                if (broken_reg != dewu_pkg::BROKEN_MAX) begin
                    broken_next = broken_reg + 1'b1;
                end
            end
            default: begin
                phase_next = dewu_pkg::PH_HEADER;
            end
        endcase
        frame.broken_total = broken_next;
    end

endmodule

`default_nettype wire

/* design/dewu_decoder.sv */
`default_nettype none

module dewu_decoder #(
    parameter int LIST_DEPTH = dewu_pkg::LIST_DEPTH_DEF,
    parameter int TRIG_DEPTH = dewu_pkg::TRIG_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           advance,
    input  wire logic [dewu_pkg::WORD_W-1:0]    word,
    input  wire logic                           new_event,
    input  wire dewu_pkg::frame_t               frame,
    output dewu_pkg::decode_t                   result
);

    localparam int LW = $clog2(LIST_DEPTH);
    localparam int TW = $clog2(TRIG_DEPTH);
    localparam logic [LW-1:0] LIST_LAST = LW'(LIST_DEPTH - 1);
    localparam logic [TW-1:0] TRIG_LAST = TW'(TRIG_DEPTH - 1);

    logic [LW-1:0] long_reg, long_next, long_cur;
    logic [LW-1:0] short_reg, short_next, short_cur;
    logic [LW-1:0] tdiff_reg, tdiff_next, tdiff_cur;
    logic [TW-1:0] trig_reg, trig_next, trig_cur;

    logic [3:0] word_type;
    logic [5:0] chan;
    logic       is_hit;
    logic       hit_long, hit_short, hit_tdiff, hit_trig;

    assign word_type = word[31:28];
    assign chan      = word[21:16];
    assign is_hit    = frame.decode && (word_type == dewu_pkg::TYPE_HIT);

    // short list sits at the top of the channel range, checked before the middle lists
    assign hit_long  = is_hit && (chan < dewu_pkg::TDIFF_BASE);
    assign hit_short = is_hit && (chan >= dewu_pkg::SHORT_BASE);
    assign hit_tdiff = is_hit && (chan >= dewu_pkg::TDIFF_BASE) && (chan < dewu_pkg::TRIG_BASE);
    assign hit_trig  = is_hit && (chan >= dewu_pkg::TRIG_BASE) && (chan < dewu_pkg::TRIG_END);

    // new event clears the counters before this word takes a slot
    assign long_cur  = new_event ? '0 : long_reg;
    assign short_cur = new_event ? '0 : short_reg;
    assign tdiff_cur = new_event ? '0 : tdiff_reg;
    assign trig_cur  = new_event ? '0 : trig_reg;

    always_comb begin
        long_next  = long_cur;
        short_next = short_cur;
        tdiff_next = tdiff_cur;
        trig_next  = trig_cur;
        if (hit_long && long_cur != LIST_LAST) begin
            long_next = long_cur + 1'b1;
        end
        if (hit_short && short_cur != LIST_LAST) begin
            short_next = short_cur + 1'b1;
        end
        if (hit_tdiff && tdiff_cur != LIST_LAST) begin
            tdiff_next = tdiff_cur + 1'b1;
        end
        if (hit_trig && trig_cur != TRIG_LAST) begin
            trig_next = trig_cur + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_reg  <= '0;
            short_reg <= '0;
            tdiff_reg <= '0;
            trig_reg  <= '0;
        end else if (advance) begin
            long_reg  <= long_next;
            short_reg <= short_next;
            tdiff_reg <= tdiff_next;
            trig_reg  <= trig_next;
        end
    end

    always_comb begin
        result.word_class  = dewu_pkg::CLS_NONE;
        result.hit_channel = '0;
        result.word_value  = '0;
        result.list_slot   = '0;
        if (frame.broken) begin
            result.word_class = dewu_pkg::CLS_BROKEN;
        end else if (hit_long) begin
            result.word_class  = dewu_pkg::CLS_LONG;
            result.hit_channel = chan[3:0];
            result.word_value  = dewu_pkg::VALUE_W'(word[15:0]);
            result.list_slot   = dewu_pkg::SLOT_W'(long_cur);
        end else if (hit_short) begin
            result.word_class  = dewu_pkg::CLS_SHORT;
            result.hit_channel = chan[3:0];
            result.word_value  = dewu_pkg::VALUE_W'(word[15:0]);
            result.list_slot   = dewu_pkg::SLOT_W'(short_cur);
        end else if (hit_tdiff) begin
            result.word_class  = dewu_pkg::CLS_TDIFF;
            result.hit_channel = chan[3:0];
            result.word_value  = dewu_pkg::VALUE_W'(word[15:0]);
            result.list_slot   = dewu_pkg::SLOT_W'(tdiff_cur);
        end else if (hit_trig) begin
            result.word_class  = dewu_pkg::CLS_TRIG;
            result.hit_channel = chan[3:0];
            result.word_value  = dewu_pkg::VALUE_W'(word[15:0]);
            result.list_slot   = dewu_pkg::SLOT_W'(trig_cur);
        end else if (frame.decode && !is_hit) begin
            if (word_type == dewu_pkg::TYPE_EXT_TS) begin
                result.word_class = dewu_pkg::CLS_EXT_TS;
                result.word_value = dewu_pkg::VALUE_W'(word[15:0]);
            end else if (word[31:30] == dewu_pkg::MARK_EVT_TS) begin
                result.word_class = dewu_pkg::CLS_EVT_TS;
                result.word_value = word[29:0];
            end
        end
    end

endmodule

`default_nettype wire

/* design/daq_event_word_unpacker.sv */
// an accepted input beat passes the input register, then the result register, to its result beat on m_ side
// throughput: one word per cycle while m_tready is high, input register and result register decouple
// the two sides so a waiting result does not stop intake of the next word
// reset: aresetn synchronous active low, empties both registers, returns framing
// to block header and clears hit counters, words left and broken count
`default_nettype none

module daq_event_word_unpacker #(
    parameter int LIST_DEPTH = dewu_pkg::LIST_DEPTH_DEF,
    parameter int TRIG_DEPTH = dewu_pkg::TRIG_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // data_word[31:0]
    input  wire logic        s_tuser,   // new_event
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // hit_channel[3:0], word_value[33:4],
                                        // list_slot[39:34], broken_total[55:40]
    output logic [2:0]       m_tuser,   // word_class
    output logic             m_tlast    // block_done
);

    logic                           in_valid_reg;
    logic [dewu_pkg::WORD_W-1:0]    in_word_reg;
    logic                           in_new_reg;
    logic                           advance;

    logic                           m_valid_reg;
    dewu_pkg::decode_t              res_reg;
    logic                           done_reg;
    logic [dewu_pkg::BROKEN_W-1:0]  broken_reg;

    dewu_pkg::frame_t               frame;
    dewu_pkg::decode_t              result;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= s_tdata;
            in_new_reg  <= s_tuser;
        end
    end

    dewu_framer u_framer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .word_len (in_word_reg[dewu_pkg::LEN_W-1:0]),
        .frame    (frame)
    );

    dewu_decoder #(
        .LIST_DEPTH (LIST_DEPTH),
        .TRIG_DEPTH (TRIG_DEPTH)
    ) u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .word      (in_word_reg),
        .new_event (in_new_reg),
        .frame     (frame),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg    <= result;
            done_reg   <= frame.done;
            broken_reg <= frame.broken_total;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.word_class;
    assign m_tlast  = done_reg;
    assign m_tdata  = {broken_reg, res_reg.list_slot, res_reg.word_value,
                       res_reg.hit_channel};

`ifndef SYNTHESIS
    // a broken-event beat always closes its block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dewu_pkg::CLS_BROKEN |-> m_tlast)
        else $error("broken beat without block end");

    // a broken-event beat carries a nonzero running count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dewu_pkg::CLS_BROKEN |-> m_tdata[55:40] != 16'd0)
        else $error("broken beat with zero broken count");

    // beats that are not hits carry no channel and no slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != dewu_pkg::CLS_LONG && m_tuser != dewu_pkg::CLS_SHORT
        && m_tuser != dewu_pkg::CLS_TDIFF && m_tuser != dewu_pkg::CLS_TRIG
        |-> m_tdata[3:0] == 4'd0 && m_tdata[39:34] == 6'd0)
        else $error("non-hit beat with channel or slot");

    // trigger slots stay inside the trigger list
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dewu_pkg::CLS_TRIG
        |-> m_tdata[39:34] <= 6'(TRIG_DEPTH - 1))
        else $error("trigger slot beyond list depth");
`endif

endmodule

`default_nettype wire
